[hdl/qteq_pkg.sv]
// package for the quantized timer expiry queue
// word types, timer entry and chain command types, field codes and default sizes
// no dependencies
package qteq_pkg;

    localparam int TIME_W           = 48;
    localparam int ID_W             = 16;
    localparam int DEF_TIMER_SLOTS  = 32;
    localparam int DEF_TIME_QUANTUM = 10;
    localparam int MAX_FIRES        = 32;

    localparam logic       FUNC_ADD  = 1'b0;
    localparam logic       FUNC_TICK = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] expiry_ms;
        logic [ID_W-1:0]   timer_id;
        logic [ID_W-1:0]   handler_tag;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   fired_id;
        logic [ID_W-1:0]   fired_handler;
        logic [TIME_W-1:0] fire_time_ms;
        logic [TIME_W-1:0] stored_expiry_ms;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   ident;
        logic [ID_W-1:0]   handler;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_chain_cmd;

endpackage

[hdl/qteq_cell.sv]
// one cell of the sorted timer chain: holds one timer entry
// depends on qteq_pkg
module qteq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qteq_pkg::t_chain_cmd i_cmd,
    input  qteq_pkg::t_entry    i_new,
    input  qteq_pkg::t_entry    i_left,
    input  logic                i_left_valid,
    input  logic                i_left_keep,
    input  qteq_pkg::t_entry    i_right,
    input  logic                i_right_valid,
    output qteq_pkg::t_entry    o_entry,
    output logic                o_valid,
    output logic                o_keep
);

    qteq_pkg::t_entry r_entry, n_entry;
    logic             r_valid, n_valid;

    // entry stays in place on insert when it is not later than the new one
    assign o_keep  = r_valid && (r_entry.expiry <= i_new.expiry);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.pop) begin
            n_entry = i_right;
            n_valid = i_right_valid;
        end else if (i_cmd.ins && !o_keep) begin
            if (i_left_keep) begin
                n_entry = i_new;
                n_valid = 1'b1;
            end else begin
                n_entry = i_left;
                n_valid = i_left_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hdl/qteq_chain.sv]
// row of timer cells kept sorted by expiry, then by insertion order
// depends on qteq_pkg and qteq_cell
module qteq_chain #(
    parameter int TIMER_SLOTS = qteq_pkg::DEF_TIMER_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qteq_pkg::t_chain_cmd i_cmd,
    input  qteq_pkg::t_entry     i_new,
    output qteq_pkg::t_entry     o_head,
    output logic                 o_head_valid,
    output qteq_pkg::t_entry     o_next,
    output logic                 o_next_valid,
    output logic                 o_full
);

    qteq_pkg::t_entry            entry [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0]      valid;
    logic [TIMER_SLOTS-1:0]      keep;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        qteq_pkg::t_entry left_entry, right_entry;
        logic             left_valid, left_keep, right_valid;

        if (g == 0) begin : g_first
            assign left_entry = '0;
            assign left_valid = 1'b0;
            assign left_keep  = 1'b1;
        end else begin : g_mid
            assign left_entry = entry[g-1];
            assign left_valid = valid[g-1];
            assign left_keep  = keep[g-1];
        end

        if (g == TIMER_SLOTS - 1) begin : g_last
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_entry = entry[g+1];
            assign right_valid = valid[g+1];
        end

        qteq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (i_cmd),
            .i_new         (i_new),
            .i_left        (left_entry),
            .i_left_valid  (left_valid),
            .i_left_keep   (left_keep),
            .i_right       (right_entry),
            .i_right_valid (right_valid),
            .o_entry       (entry[g]),
            .o_valid       (valid[g]),
            .o_keep        (keep[g])
        );
    end

    assign o_head       = entry[0];
    assign o_head_valid = valid[0];
    assign o_next       = entry[1];
    assign o_next_valid = valid[1];
    assign o_full       = valid[TIMER_SLOTS-1];

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.ins && i_cmd.pop))
        else $error("insert and pop in the same cycle");

    for (genvar g = 0; g < TIMER_SLOTS - 1; g++) begin : g_chk
        a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            valid[g+1] |-> valid[g])
            else $error("gap in timer chain");
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            valid[g+1] |-> (entry[g].expiry <= entry[g+1].expiry))
            else $error("timer chain out of order");
    end

endmodule

[hdl/qteq_quant.sv]
// rounds a time value down to a multiple of the quantum in four pipelined steps
// depends on qteq_pkg
module qteq_quant #(
    parameter int TIME_QUANTUM = qteq_pkg::DEF_TIME_QUANTUM
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qteq_pkg::TIME_W-1:0] i_value,
    output logic                        o_done,
    output logic [qteq_pkg::TIME_W-1:0] o_result
);

    localparam int              CW = qteq_pkg::TIME_W / 3;
    localparam int              LW = $clog2(TIME_QUANTUM);
    localparam int              SW = CW + $clog2(2 * TIME_QUANTUM);
    localparam int              MW = SW + 1;
    localparam int              PW = SW + MW;
    localparam int              SH = SW + LW;
    localparam longint unsigned QL = 64'(TIME_QUANTUM);
    localparam logic [SW-1:0]   K1 = SW'((64'd1 << CW) % QL);
    localparam logic [SW-1:0]   K2 = SW'((64'd1 << (2 * CW)) % QL);
    localparam logic [SW-1:0]   KQ = SW'(QL);
    localparam logic [MW-1:0]   KM = MW'(((64'd1 << SH) + QL - 64'd1) / QL);

    logic [qteq_pkg::TIME_W-1:0] r_val, r_result;
    logic [SW-1:0]               r_sum, r_quo, r_rem, fold;
    logic [PW-1:0]               prod;
    logic [4:0]                  r_step;

    // three 16-bit chunks weighted by their powers of two modulo the quantum
    assign fold = SW'(r_val[3*CW-1:2*CW]) * K2 + SW'(r_val[2*CW-1:CW]) * K1
                + SW'(r_val[CW-1:0]);

    // scaled reciprocal gives the exact quotient of the folded sum
    assign prod = PW'(r_sum) * PW'(KM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= {r_step[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_step[0]) begin
            r_sum <= fold;
        end
        if (r_step[1]) begin
            r_quo <= SW'(prod >> SH);
        end
        if (r_step[2]) begin
            r_rem <= r_sum - r_quo * KQ;
        end
        if (r_step[3]) begin
            r_result <= r_val - qteq_pkg::TIME_W'(r_rem);
        end
    end

    assign o_done   = r_step[4];
    assign o_result = r_result;

endmodule

[hdl/quantized_timer_expiry_queue_top.sv]
// top level of the quantized timer expiry queue: control, output register
// depends on qteq_pkg, qteq_quant, qteq_chain
//
//   channel  valid        stall         word
//   input    i_in_valid   o_in_stall    i_in_word  (qteq_pkg::t_in_word)
//   output   o_out_valid  i_out_stall   o_out_word (qteq_pkg::t_out_word)
//
// every word first passes through the rounding unit: fold, reciprocal multiply, subtracts
// an add then inserts its entry, or rejects it when the chain is full, and queues its result
// a tick fires due timers, at most 32 per tick; one fire a cycle while the output is not stalled
// a stalled output holds the block in its add or fire state; a new word is taken once the last result is queued
// reset empties the timer chain at once
module quantized_timer_expiry_queue_top #(
    parameter int TIMER_SLOTS  = qteq_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_QUANTUM = qteq_pkg::DEF_TIME_QUANTUM
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  qteq_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output qteq_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    localparam int FW = $clog2(qteq_pkg::MAX_FIRES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_QUANT = 4'b0010,
        S_ADD   = 4'b0100,
        S_FIRE  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [FW-1:0]                 r_fires, n_fires;
    logic                          r_func;
    logic [qteq_pkg::ID_W-1:0]     r_id, r_hd;
    logic                          r_out_valid;
    qteq_pkg::t_out_word           r_out_word, e_word;
    logic                          emit, in_accept, out_free;
    logic                          q_done;
    logic [qteq_pkg::TIME_W-1:0]   q_value, q_time;
    qteq_pkg::t_chain_cmd          cmd;
    qteq_pkg::t_entry              new_entry, head, next;
    logic                          head_valid, next_valid, full;
    logic                          due0, due1, fire_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign q_value = (i_in_word.func == qteq_pkg::FUNC_TICK) ? i_in_word.now_ms
                                                             : i_in_word.expiry_ms;

    qteq_quant #(
        .TIME_QUANTUM (TIME_QUANTUM)
    ) u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_value  (q_value),
        .o_done   (q_done),
        .o_result (q_time)
    );

    assign new_entry = '{expiry: q_time, ident: r_id, handler: r_hd};

    qteq_chain #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_new        (new_entry),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_next       (next),
        .o_next_valid (next_valid),
        .o_full       (full)
    );

    assign due0      = head_valid && (head.expiry <= q_time);
    assign due1      = next_valid && (next.expiry <= q_time);
    assign fire_last = !due1 || (r_fires == FW'(qteq_pkg::MAX_FIRES - 1));

    always_comb begin
        n_state = r_state;
        n_fires = r_fires;
        cmd     = '0;
        emit    = 1'b0;
        e_word  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_QUANT;
                    n_fires = '0;
                end
            end
            S_QUANT: begin
                if (q_done) begin
                    if (r_func == qteq_pkg::FUNC_TICK) begin
                        n_state = S_FIRE;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    emit                    = 1'b1;
                    e_word.kind             = full ? qteq_pkg::KIND_REJECTED
                                                   : qteq_pkg::KIND_ACCEPTED;
                    e_word.fired_id         = r_id;
                    e_word.fired_handler    = r_hd;
                    e_word.stored_expiry_ms = q_time;
                    e_word.last             = 1'b1;
                    cmd.ins                 = !full;
                    n_state                 = S_IDLE;
                end
            end
            S_FIRE: begin
                if (!due0) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    emit                    = 1'b1;
                    e_word.kind             = qteq_pkg::KIND_FIRED;
                    e_word.fired_id         = head.ident;
                    e_word.fired_handler    = head.handler;
                    e_word.fire_time_ms     = q_time;
                    e_word.stored_expiry_ms = head.expiry;
                    e_word.last             = fire_last;
                    cmd.pop                 = 1'b1;
                    n_fires                 = r_fires + 1'b1;
                    if (fire_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fires     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fires <= n_fires;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_in_word.func;
            r_id   <= i_in_word.timer_id;
            r_hd   <= i_in_word.handler_tag;
        end
        if (emit) begin
            r_out_word <= e_word;
        end
    end

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |-> !full)
        else $error("insert into full chain");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> (head_valid && r_state == S_FIRE))
        else $error("pop without a due head");

    a_quant_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_done |-> (r_state == S_QUANT))
        else $error("rounding unit finished outside its state");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_out_stall))
        else $error("result written over a held word");

endmodule

[tb/quantized_timer_expiry_queue_top_tb.sv]
`timescale 1ns / 100ps
// testbench for quantized_timer_expiry_queue_top: directed and random add and tick words
// a scoreboard class predicts accepted, rejected and fired results and checks each output word
// depends on qteq_pkg and the rtl of the block
module quantized_timer_expiry_queue_top_tb;

    localparam int                          SLOTS    = qteq_pkg::DEF_TIMER_SLOTS;
    localparam int                          QUANTUM  = qteq_pkg::DEF_TIME_QUANTUM;
    localparam logic [qteq_pkg::TIME_W-1:0] TIME_MAX = '1;

    class timer_scoreboard;
        logic                        slot_used    [SLOTS];
        logic [qteq_pkg::TIME_W-1:0] slot_expiry  [SLOTS];
        logic [qteq_pkg::ID_W-1:0]   slot_id      [SLOTS];
        logic [qteq_pkg::ID_W-1:0]   slot_handler [SLOTS];
        int unsigned                 slot_order   [SLOTS];
        int unsigned                 add_count;
        qteq_pkg::t_out_word         awaited_responses [$];
        int                          error_count;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            add_count   = 0;
            error_count = 0;
        endfunction

        function logic [qteq_pkg::TIME_W-1:0] quantize_ms(logic [qteq_pkg::TIME_W-1:0] t);
            return (t / qteq_pkg::TIME_W'(QUANTUM)) * qteq_pkg::TIME_W'(QUANTUM);
        endfunction

        function void note_in_word(qteq_pkg::t_in_word w);
            qteq_pkg::t_out_word         r;
            qteq_pkg::t_out_word         held;
            logic                        have_held;
            int                          free_slot;
            int                          best;
            int                          n_fired;
            logic [qteq_pkg::TIME_W-1:0] now;
            r = '0;
            if (w.func == qteq_pkg::FUNC_ADD) begin
                r.fired_id         = w.timer_id;
                r.fired_handler    = w.handler_tag;
                r.stored_expiry_ms = quantize_ms(w.expiry_ms);
                r.last             = 1'b1;
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_used[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) begin
                    r.kind = qteq_pkg::KIND_REJECTED;
                end else begin
                    r.kind                  = qteq_pkg::KIND_ACCEPTED;
                    slot_used[free_slot]    = 1'b1;
                    slot_expiry[free_slot]  = r.stored_expiry_ms;
                    slot_id[free_slot]      = w.timer_id;
                    slot_handler[free_slot] = w.handler_tag;
                    slot_order[free_slot]   = add_count;
                    add_count++;
                end
                awaited_responses = {awaited_responses, r};
            end else begin
                now       = quantize_ms(w.now_ms);
                have_held = 1'b0;
                held      = '0;
                n_fired   = 0;
                best      = 0;
                while (n_fired < qteq_pkg::MAX_FIRES && best >= 0) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_expiry[i] <= now) begin
                            if (best < 0 || slot_expiry[i] < slot_expiry[best] ||
                                (slot_expiry[i] == slot_expiry[best] &&
                                 slot_order[i] < slot_order[best])) begin
                                best = i;
                            end
                        end
                    end
                    if (best >= 0) begin
                        if (have_held) awaited_responses = {awaited_responses, held};
                        held.kind             = qteq_pkg::KIND_FIRED;
                        held.fired_id         = slot_id[best];
                        held.fired_handler    = slot_handler[best];
                        held.fire_time_ms     = now;
                        held.stored_expiry_ms = slot_expiry[best];
                        held.last             = 1'b0;
                        have_held             = 1'b1;
                        slot_used[best]       = 1'b0;
                        n_fired++;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    awaited_responses = {awaited_responses, held};
                end
            end
        endfunction

        function void compare_field(string name, logic [qteq_pkg::TIME_W-1:0] want,
                                    logic [qteq_pkg::TIME_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_out_word(qteq_pkg::t_out_word got);
            qteq_pkg::t_out_word want;
            if (awaited_responses.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                error_count++;
                return;
            end
            want = awaited_responses[0];
            awaited_responses.delete(0);
            compare_field("kind", qteq_pkg::TIME_W'(want.kind), qteq_pkg::TIME_W'(got.kind));
            compare_field("fired_id", qteq_pkg::TIME_W'(want.fired_id),
                          qteq_pkg::TIME_W'(got.fired_id));
            compare_field("fired_handler", qteq_pkg::TIME_W'(want.fired_handler),
                          qteq_pkg::TIME_W'(got.fired_handler));
            compare_field("fire_time_ms", want.fire_time_ms, got.fire_time_ms);
            compare_field("stored_expiry_ms", want.stored_expiry_ms, got.stored_expiry_ms);
            compare_field("last", qteq_pkg::TIME_W'(want.last), qteq_pkg::TIME_W'(got.last));
        endfunction

        function int pending();
            return awaited_responses.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    qteq_pkg::t_in_word          in_word;
    logic                        in_stall;
    logic                        out_valid;
    qteq_pkg::t_out_word         out_word;
    logic                        out_stall;
    int                          src_idle_pct;
    int                          snk_idle_pct;
    timer_scoreboard             sb;
    logic [qteq_pkg::TIME_W-1:0] cur_time;
    logic [qteq_pkg::TIME_W-1:0] last_expiry;
    int                          fill_left;

    quantized_timer_expiry_queue_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("quantized_timer_expiry_queue_top_tb: done, errors");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_out_word(out_word);
        out_stall <= rst_n && ($urandom_range(0, 99) < snk_idle_pct);
    end

    function automatic logic [qteq_pkg::TIME_W-1:0] rand48();
        return {16'($urandom_range(0, 65535)), 32'($urandom())};
    endfunction

    function automatic logic [qteq_pkg::ID_W-1:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    // unused fields carry random bits
    function automatic qteq_pkg::t_in_word add_word(logic [qteq_pkg::TIME_W-1:0] expiry,
                                                    logic [qteq_pkg::ID_W-1:0] id,
                                                    logic [qteq_pkg::ID_W-1:0] handler);
        qteq_pkg::t_in_word w;
        w.func        = qteq_pkg::FUNC_ADD;
        w.expiry_ms   = expiry;
        w.timer_id    = id;
        w.handler_tag = handler;
        w.now_ms      = rand48();
        return w;
    endfunction

    function automatic qteq_pkg::t_in_word tick_word(logic [qteq_pkg::TIME_W-1:0] now);
        qteq_pkg::t_in_word w;
        w.func        = qteq_pkg::FUNC_TICK;
        w.expiry_ms   = rand48();
        w.timer_id    = rand16();
        w.handler_tag = rand16();
        w.now_ms      = now;
        return w;
    endfunction

    function automatic qteq_pkg::t_in_word next_random_word();
        qteq_pkg::t_in_word          w;
        int                          pick;
        logic [qteq_pkg::TIME_W-1:0] expiry;
        if (fill_left > 0) begin
            fill_left--;
            return add_word(cur_time + qteq_pkg::TIME_W'($urandom_range(0, 600)),
                            rand16(), rand16());
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            // burst of adds past the table size
            fill_left = SLOTS + 3;
            return add_word(cur_time + qteq_pkg::TIME_W'($urandom_range(0, 600)),
                            rand16(), rand16());
        end
        if (pick < 12) begin
            w.func        = 1'($urandom_range(0, 1));
            w.expiry_ms   = rand48();
            w.timer_id    = rand16();
            w.handler_tag = rand16();
            w.now_ms      = rand48();
            return w;
        end
        if (pick < 15) return tick_word(TIME_MAX - qteq_pkg::TIME_W'($urandom_range(0, 9)));
        if (pick < 62) begin
            if ($urandom_range(0, 3) == 0) begin
                expiry = (last_expiry / qteq_pkg::TIME_W'(QUANTUM)) *
                         qteq_pkg::TIME_W'(QUANTUM) +
                         qteq_pkg::TIME_W'($urandom_range(0, QUANTUM - 1));
            end else begin
                expiry = cur_time + qteq_pkg::TIME_W'($urandom_range(0, 500));
            end
            last_expiry = expiry;
            return add_word(expiry, rand16(), rand16());
        end
        cur_time = cur_time + qteq_pkg::TIME_W'($urandom_range(0, 200));
        return tick_word(cur_time);
    endfunction

    task automatic send_word(input qteq_pkg::t_in_word w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_in_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial begin
        sb           = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_word     <= '0;
        cur_time     = '0;
        last_expiry  = '0;
        fill_left    = 0;
        src_idle_pct = 31;
        snk_idle_pct = 53;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, rounding and equal expiries in insertion order
        send_word(add_word('0, 16'h0000, 16'h0000));
        send_word(add_word(TIME_MAX, 16'hFFFF, 16'hFFFF));
        send_word(add_word(48'd9, 16'h0001, 16'h1111));
        send_word(add_word(48'd15, 16'h0002, 16'h2222));
        send_word(add_word(48'd10, 16'h0003, 16'h3333));
        send_word(tick_word('0));
        send_word(tick_word(48'd5));
        send_word(tick_word(48'd19));
        send_word(tick_word(TIME_MAX));
        send_word(add_word(48'd100, 16'h0004, 16'h4444));
        send_word(add_word(48'd105, 16'h0005, 16'h5555));
        send_word(add_word(48'd109, 16'h0006, 16'h6666));
        send_word(tick_word(48'd99));
        send_word(tick_word(48'd100));
        // removal between equal expiries keeps the order of the rest
        send_word(add_word(48'd200, 16'h0007, 16'h7777));
        send_word(add_word(48'd300, 16'h0008, 16'h8888));
        send_word(add_word(48'd200, 16'h0009, 16'h9999));
        send_word(tick_word(48'd250));
        send_word(add_word(48'd300, 16'h000A, 16'hAAAA));
        send_word(tick_word(48'd309));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 53 : 0;
            snk_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 31 : 0;
            for (int n = 0; n < 87; n++) send_word(next_random_word());
            wait_drained();
        end

        repeat (64) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("quantized_timer_expiry_queue_top_tb: done, clean");
        end else begin
            $display("quantized_timer_expiry_queue_top_tb: done, errors");
        end
        $finish;
    end
endmodule

[files.f]
hdl/qteq_pkg.sv
hdl/qteq_cell.sv
hdl/qteq_chain.sv
hdl/qteq_quant.sv
hdl/quantized_timer_expiry_queue_top.sv
tb/quantized_timer_expiry_queue_top_tb.sv
